>>> src/ecmd_pkg.sv
// ----------------------------------------------------------------------------
// ecmd_pkg: shared codes and helpers for the elevator car controller
// Motion, door, function and error codes, and divider constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ecmd_pkg;

  // Motion state codes, as shown on motion_state
  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_ACCEL   = 2'd1;
  localparam logic [1:0] MODE_DECEL   = 2'd2;
  localparam logic [1:0] MODE_MAXV    = 2'd3;

  // Door phase codes
  localparam logic [1:0] DOOR_CLOSED  = 2'd0;
  localparam logic [1:0] DOOR_OPENING = 2'd1;
  localparam logic [1:0] DOOR_OPEN    = 2'd2;
  localparam logic [1:0] DOOR_CLOSING = 2'd3;

  // Item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ENTER = 2'd1;
  localparam logic [1:0] FUNC_EXIT  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_VEL   = 3'd0;
  localparam logic [2:0] REG_ACCEL     = 3'd1;
  localparam logic [2:0] REG_DECEL     = 3'd2;
  localparam logic [2:0] REG_MIN_ALT   = 3'd3;
  localparam logic [2:0] REG_MAX_ALT   = 3'd4;
  localparam logic [2:0] REG_DOOR_MOVE = 3'd5;
  localparam logic [2:0] REG_DOOR_HOLD = 3'd6;
  localparam logic [2:0] REG_PASS_LIM  = 3'd7;

  // Divider: 44-bit dividend, 4 quotient bits per step
  localparam int unsigned DIV_W      = 44;
  localparam int unsigned DIV_DIGIT  = 4;
  localparam int unsigned DIV_STEPS  = DIV_W / DIV_DIGIT;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [19:0] US_PER_MS  = 20'd1000;

  localparam logic [16:0] TIMER_MAX = 17'd131071;
  localparam logic [23:0] LOAD_MAX  = 24'hFFFFFF;
  localparam logic [5:0]  RIDERS_MAX = 6'd63;
  localparam logic [31:0] NEAR_UM   = 32'd10000;

  // Car within 1 cm of the target
  function automatic logic near_target(input logic [30:0] tgt, input logic [30:0] hgt);
    logic [31:0] d;
    d = {1'b0, tgt} - {1'b0, hgt};
    if (d[31]) begin
      d = -d;
    end
    return d <= NEAR_UM;
  endfunction

endpackage

`default_nettype wire

>>> src/elevator_car_motion_and_door.sv
// ----------------------------------------------------------------------------
// elevator_car_motion_and_door: elevator car motion, door and load controller
// Timing: enter, exit and unused items give their result in the cycle after the
//   transfer; a tick steps the door timer and, with the door closed, the motion
//   profile and the car position (one shared multiplier, one 4-bit-per-cycle
//   divider run up to three times).
// Throughput: one item at a time; the next transfer waits for the result.
// Reset: state and configuration registers take their reset values at once.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_car_motion_and_door (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_wdata_i,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [19:0] delta_us_i,
  input  wire logic [30:0] target_altitude_i,
  input  wire logic [18:0] person_weight_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  motion_state_o,
  output logic      [1:0]  door_phase_o,
  output logic             moving_up_o,
  output logic      [30:0] altitude_now_o,
  output logic      [23:0] speed_now_o,
  output logic      [5:0]  passenger_count_o,
  output logic      [23:0] load_grams_o,
  output logic      [1:0]  error_code_o
);

  // Sequencer states
  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_DOOR   = 16'h0002,  // start door timer division
    ST_DWAIT  = 16'h0004,  // advance door phase
    ST_CHK    = 16'h0008,  // arrival check, start v*v
    ST_SQ     = 16'h0010,
    ST_PLO    = 16'h0020,
    ST_PHI    = 16'h0040,  // braking distance compare
    ST_MODE   = 16'h0080,  // mode step, start rate*dt
    ST_RMUL   = 16'h0100,
    ST_RDIV   = 16'h0200,  // apply speed change
    ST_DMUL   = 16'h0400,  // start v*dt
    ST_DSTART = 16'h0800,
    ST_DDIV   = 16'h1000,  // move the car
    ST_CLMAX  = 16'h2000,
    ST_CLMIN  = 16'h4000,
    ST_OUT    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [23:0] max_vel_q, accel_q, decel_q;
  logic [30:0] min_alt_q, max_alt_q;
  logic [15:0] door_move_q, door_hold_q;
  logic [5:0]  pass_lim_q;

  // Car state
  logic [1:0]  mode_q, mode_d;
  logic [1:0]  door_q, door_d;
  logic        up_q, up_d;
  logic [30:0] height_q, height_d;
  logic [23:0] speed_q, speed_d;
  logic [16:0] timer_q, timer_d;
  logic [5:0]  riders_q, riders_d;
  logic [23:0] load_q, load_d;
  logic [1:0]  err_q, err_d;

  // Item and scratch registers
  logic [19:0] dus_q, dus_d;
  logic [30:0] tgt_q, tgt_d;
  logic [47:0] sq_q, sq_d;
  logic [39:0] plo_q, plo_d;
  logic signed [32:0] hs_q, hs_d;

  // Shared units
  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p;
  logic        div_start, div_ms, div_done;
  logic [43:0] div_dividend, div_quot;

  ecmd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ecmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .ms_i       (div_ms),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic [23:0] dec_eff;
  logic [30:0] gap;
  logic [31:0] dist_raw;

  assign dec_eff  = (decel_q == 24'd0) ? 24'd1 : decel_q;
  assign dist_raw = {1'b0, tgt_q} - {1'b0, height_q};
  assign gap      = dist_raw[31] ? 31'(-dist_raw) : dist_raw[30:0];

  // Configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_vel_q   <= 24'd1000000;
      accel_q     <= 24'd500000;
      decel_q     <= 24'd500000;
      min_alt_q   <= 31'd0;
      max_alt_q   <= 31'd30000000;
      door_move_q <= 16'd2000;
      door_hold_q <= 16'd3000;
      pass_lim_q  <= 6'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecmd_pkg::REG_MAX_VEL:   max_vel_q   <= cfg_wdata_i[23:0];
        ecmd_pkg::REG_ACCEL:     accel_q     <= cfg_wdata_i[23:0];
        ecmd_pkg::REG_DECEL:     decel_q     <= cfg_wdata_i[23:0];
        ecmd_pkg::REG_MIN_ALT:   min_alt_q   <= cfg_wdata_i;
        ecmd_pkg::REG_MAX_ALT:   max_alt_q   <= cfg_wdata_i;
        ecmd_pkg::REG_DOOR_MOVE: door_move_q <= cfg_wdata_i[15:0];
        ecmd_pkg::REG_DOOR_HOLD: door_hold_q <= cfg_wdata_i[15:0];
        ecmd_pkg::REG_PASS_LIM:  pass_lim_q  <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand select: the product shows up in the following state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_CHK: begin
        mul_a = speed_q;
        mul_b = speed_q;
      end
      ST_SQ: begin
        mul_a = dec_eff;
        mul_b = {8'd0, gap[15:0]};
      end
      ST_PLO: begin
        mul_a = dec_eff;
        mul_b = {9'd0, gap[30:16]};
      end
      ST_MODE: begin
        mul_a = (mode_q == ecmd_pkg::MODE_ACCEL) ? accel_q : dec_eff;
        mul_b = {4'd0, dus_q};
      end
      ST_DMUL: begin
        mul_a = speed_q;
        mul_b = {4'd0, dus_q};
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    logic [17:0] tsum;
    logic [16:0] tnew;
    logic [55:0] brake;
    logic [25:0] vsum;
    logic [24:0] q25;
    logic [24:0] load_sum;
    state_d   = state_q;
    mode_d    = mode_q;
    door_d    = door_q;
    up_d      = up_q;
    height_d  = height_q;
    speed_d   = speed_q;
    timer_d   = timer_q;
    riders_d  = riders_q;
    load_d    = load_q;
    err_d     = err_q;
    dus_d     = dus_q;
    tgt_d     = tgt_q;
    sq_d      = sq_q;
    plo_d     = plo_q;
    hs_d      = hs_q;
    div_start    = 1'b0;
    div_ms       = 1'b0;
    div_dividend = mul_p[43:0];
    q25      = div_quot[24:0];
    tsum     = {1'b0, timer_q} + {7'd0, div_quot[10:0]};
    tnew     = (tsum > {1'b0, ecmd_pkg::TIMER_MAX}) ? ecmd_pkg::TIMER_MAX : tsum[16:0];
    brake    = {16'd0, plo_q} + {1'b0, mul_p[38:0], 16'd0};
    vsum     = {2'd0, speed_q} + {1'b0, q25};
    load_sum = {1'b0, load_q} + {6'd0, person_weight_i};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dus_d = delta_us_i;
          tgt_d = target_altitude_i;
          err_d = ecmd_pkg::ERR_NONE;
          state_d = ST_OUT;
          unique case (func_i)
            ecmd_pkg::FUNC_TICK: state_d = ST_DOOR;
            ecmd_pkg::FUNC_ENTER: begin
              if (riders_q >= pass_lim_q || riders_q >= ecmd_pkg::RIDERS_MAX) begin
                err_d = ecmd_pkg::ERR_FULL;
              end else begin
                load_d   = load_sum[24] ? ecmd_pkg::LOAD_MAX : load_sum[23:0];
                riders_d = riders_q + 6'd1;
              end
            end
            ecmd_pkg::FUNC_EXIT: begin
              if (riders_q == 6'd0) begin
                err_d = ecmd_pkg::ERR_EMPTY;
              end else begin
                load_d   = (load_q > {5'd0, person_weight_i}) ?
                           load_q - {5'd0, person_weight_i} : 24'd0;
                riders_d = riders_q - 6'd1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DOOR: begin
        if (speed_q == 24'd0 && door_q != ecmd_pkg::DOOR_CLOSED) begin
          div_start    = 1'b1;
          div_ms       = 1'b1;
          div_dividend = {24'd0, dus_q};
          state_d      = ST_DWAIT;
        end else begin
          state_d = ST_CHK;
        end
      end

      ST_DWAIT: begin
        if (div_done) begin
          timer_d = tnew;
          state_d = ST_OUT;
          unique case (door_q)
            ecmd_pkg::DOOR_OPEN: begin
              if (tnew >= {1'b0, door_hold_q}) begin
                door_d  = ecmd_pkg::DOOR_CLOSING;
                timer_d = '0;
              end
            end
            ecmd_pkg::DOOR_OPENING: begin
              if (tnew >= {1'b0, door_move_q}) begin
                door_d  = ecmd_pkg::DOOR_OPEN;
                timer_d = '0;
              end
            end
            ecmd_pkg::DOOR_CLOSING: begin
              if (tnew >= {1'b0, door_move_q}) begin
                door_d  = ecmd_pkg::DOOR_CLOSED;
                timer_d = '0;
                state_d = ST_CHK;
              end
            end
            default: state_d = ST_CHK;
          endcase
        end
      end

      ST_CHK: begin
        if (speed_q == 24'd0 && ecmd_pkg::near_target(tgt_q, height_q)) begin
          state_d = ST_OUT;
        end else if (mode_q == ecmd_pkg::MODE_ACCEL || mode_q == ecmd_pkg::MODE_MAXV) begin
          state_d = ST_SQ;
        end else begin
          state_d = ST_MODE;
        end
      end

      ST_SQ: begin
        sq_d    = mul_p;
        state_d = ST_PLO;
      end

      ST_PLO: begin
        plo_d   = mul_p[39:0];
        state_d = ST_PHI;
      end

      ST_PHI: begin
        // brake once 2*dist*dec falls to v*v or below
        if ({brake, 1'b0} <= {9'd0, sq_q}) begin
          mode_d = ecmd_pkg::MODE_DECEL;
        end
        state_d = ST_MODE;
      end

      ST_MODE: begin
        state_d = ST_DMUL;
        unique case (mode_q)
          ecmd_pkg::MODE_STOPPED: begin
            up_d   = (tgt_q > height_q);
            mode_d = ecmd_pkg::MODE_ACCEL;
          end
          ecmd_pkg::MODE_ACCEL: begin
            if (speed_q < max_vel_q) begin
              state_d = ST_RMUL;
            end
          end
          ecmd_pkg::MODE_DECEL: begin
            if (speed_q != 24'd0) begin
              state_d = ST_RMUL;
            end
          end
          default: ;
        endcase
      end

      ST_RMUL: begin
        div_start = 1'b1;
        state_d   = ST_RDIV;
      end

      ST_RDIV: begin
        if (div_done) begin
          state_d = ST_DMUL;
          if (mode_q == ecmd_pkg::MODE_ACCEL) begin
            if (vsum > {2'd0, max_vel_q}) begin
              speed_d = max_vel_q;
              mode_d  = ecmd_pkg::MODE_MAXV;
            end else begin
              speed_d = vsum[23:0];
            end
          end else begin
            if (q25 >= {1'b0, speed_q}) begin
              mode_d  = ecmd_pkg::MODE_STOPPED;
              speed_d = '0;
              if (ecmd_pkg::near_target(tgt_q, height_q)) begin
                door_d  = ecmd_pkg::DOOR_OPENING;
                timer_d = '0;
              end
            end else begin
              speed_d = speed_q - q25[23:0];
            end
          end
        end
      end

      ST_DMUL: state_d = ST_DSTART;

      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DDIV;
      end

      ST_DDIV: begin
        if (div_done) begin
          hs_d = up_q ? $signed({2'b00, height_q}) + $signed({8'd0, q25})
                      : $signed({2'b00, height_q}) - $signed({8'd0, q25});
          state_d = ST_CLMAX;
        end
      end

      ST_CLMAX: begin
        // clamp at the top of the shaft and stop
        if (hs_q > $signed({2'b00, max_alt_q})) begin
          hs_d    = $signed({2'b00, max_alt_q});
          mode_d  = ecmd_pkg::MODE_STOPPED;
          speed_d = '0;
          if (ecmd_pkg::near_target(tgt_q, max_alt_q)) begin
            door_d  = ecmd_pkg::DOOR_OPENING;
            timer_d = '0;
          end
        end
        state_d = ST_CLMIN;
      end

      ST_CLMIN: begin
        // clamp at the bottom; this one wins over the top
        height_d = hs_q[30:0];
        if (hs_q < $signed({2'b00, min_alt_q})) begin
          height_d = min_alt_q;
          mode_d   = ecmd_pkg::MODE_STOPPED;
          speed_d  = '0;
          if (ecmd_pkg::near_target(tgt_q, min_alt_q)) begin
            door_d  = ecmd_pkg::DOOR_OPENING;
            timer_d = '0;
          end
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= ecmd_pkg::MODE_STOPPED;
      door_q   <= ecmd_pkg::DOOR_CLOSED;
      up_q     <= 1'b0;
      height_q <= '0;
      speed_q  <= '0;
      timer_q  <= '0;
      riders_q <= '0;
      load_q   <= '0;
      err_q    <= ecmd_pkg::ERR_NONE;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      door_q   <= door_d;
      up_q     <= up_d;
      height_q <= height_d;
      speed_q  <= speed_d;
      timer_q  <= timer_d;
      riders_q <= riders_d;
      load_q   <= load_d;
      err_q    <= err_d;
    end
  end

  // Item scratch: payload only, no reset
  always_ff @(posedge clk_i) begin
    dus_q <= dus_d;
    tgt_q <= tgt_d;
    sq_q  <= sq_d;
    plo_q <= plo_d;
    hs_q  <= hs_d;
  end

  // Ports: hold the result in the car state registers until the transfer
  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = (state_q == ST_OUT);
  assign motion_state_o    = mode_q;
  assign door_phase_o      = door_q;
  assign moving_up_o       = up_q;
  assign altitude_now_o    = height_q;
  assign speed_now_o       = speed_q;
  assign passenger_count_o = riders_q;
  assign load_grams_o      = load_q;
  assign error_code_o      = err_q;

endmodule

`default_nettype wire

>>> src/ecmd_mul.sv
// ----------------------------------------------------------------------------
// ecmd_mul: shared registered multiplier
// Unsigned 24 x 24 product, registered and available in the cycle after the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmd_mul (
  input  wire logic        clk_i,
  input  wire logic [23:0] a_i,
  input  wire logic [23:0] b_i,
  output logic      [47:0] p_o
);

  logic [47:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {24'd0, a_i} * {24'd0, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> src/ecmd_div.sv
// ----------------------------------------------------------------------------
// ecmd_div: iterative divider by a fixed constant
// Restoring division by 1000000 or 1000, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        ms_i,       // divide by 1000 instead of 1000000
  input  wire logic [43:0] dividend_i,
  output logic             done_o,
  output logic      [43:0] quot_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [19:0] rem_q, rem_d;
  logic [19:0] dsr_q, dsr_d;
  logic [43:0] sh_q, sh_d;

  always_comb begin
    logic [20:0] r;
    logic [43:0] s;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    sh_d   = sh_q;
    r      = {1'b0, rem_q};
    s      = sh_q;
    if (start_i) begin
      cnt_d = 4'(ecmd_pkg::DIV_STEPS);
      rem_d = '0;
      dsr_d = ms_i ? ecmd_pkg::US_PER_MS : ecmd_pkg::US_PER_S;
      sh_d  = dividend_i;
    end else if (cnt_q != 4'd0) begin
      // shift one dividend bit in per quotient bit, subtract where it fits
      for (int i = 0; i < int'(ecmd_pkg::DIV_DIGIT); i++) begin
        r = {r[19:0], s[43]};
        s = {s[42:0], 1'b0};
        if (r >= {1'b0, dsr_q}) begin
          r    = r - {1'b0, dsr_q};
          s[0] = 1'b1;
        end
      end
      rem_d  = r[19:0];
      sh_d   = s;
      cnt_d  = cnt_q - 4'd1;
      done_d = (cnt_q == 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

>>> src/ecmd_chk.sv
// ----------------------------------------------------------------------------
// ecmd_chk: port-level checks for the elevator car controller
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ecmd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  motion_state_o,
  input wire logic [1:0]  door_phase_o,
  input wire logic [30:0] altitude_now_o,
  input wire logic [23:0] speed_now_o,
  input wire logic [5:0]  passenger_count_o,
  input wire logic [1:0]  error_code_o
);

  // One item at a time: never take input while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(altitude_now_o)
      && $stable(speed_now_o) && $stable(passenger_count_o))
    else $error("stalled result changed");

  // A stopped car has zero speed
  a_stop_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_state_o == ecmd_pkg::MODE_STOPPED |-> speed_now_o == 24'd0)
    else $error("stopped car reports speed");

  // The door is never away from closed while the car moves
  a_door_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && door_phase_o != ecmd_pkg::DOOR_CLOSED |-> speed_now_o == 24'd0)
    else $error("door not closed while moving");

  // An empty-car error only shows with nobody aboard
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ecmd_pkg::ERR_EMPTY |-> passenger_count_o == 6'd0)
    else $error("empty-car error with riders aboard");

endmodule

bind elevator_car_motion_and_door ecmd_chk u_ecmd_chk (.*);

`default_nettype wire

>>> tb/sv/tb_elevator_car_motion_and_door.sv
// ----------------------------------------------------------------------------
// tb_elevator_car_motion_and_door: self-checking bench for the car controller
// Drives ticks, enters and exits over valid/ready, predicts every result with
// a behavioral copy of the motion, door and load rules, and compares each
// transfer field by field. Configuration is rewritten between idle phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_elevator_car_motion_and_door;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  door;
    logic        up;
    logic [30:0] alt;
    logic [23:0] spd;
    logic [5:0]  riders;
    logic [23:0] load;
    logic [1:0]  err;
  } car_view_t;

  typedef struct {
    logic [1:0]  func;
    logic [19:0] dus;
    logic [30:0] tgt;
    logic [18:0] wgt;
    logic        has_exp;
    car_view_t   exp_view;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [30:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] func_i = '0;
  logic [19:0] delta_us_i = '0;
  logic [30:0] target_altitude_i = '0;
  logic [18:0] person_weight_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] motion_state_o, door_phase_o, error_code_o;
  logic moving_up_o;
  logic [30:0] altitude_now_o;
  logic [23:0] speed_now_o, load_grams_o;
  logic [5:0] passenger_count_o;

  elevator_car_motion_and_door uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Car model: configuration and state
  longint unsigned c_vmax, c_acc, c_dec, c_min, c_max, c_move, c_hold, c_plim;
  logic [1:0] m_mode, m_door;
  logic m_up;
  longint m_hgt;
  longint unsigned m_spd, m_timer, m_riders, m_load;

  car_view_t pending_views[$];
  int unsigned errors = 0, n_sent = 0, n_seen = 0, n_ticks = 0, n_moving = 0;
  int unsigned cycles = 0;
  int unsigned idle_in = 0, idle_out = 0;
  logic hold_off = 1'b0;

  function automatic bit car_near(longint tgt);
    longint d;
    d = tgt - m_hgt;
    if (d < 0) d = -d;
    return d <= 10000;
  endfunction

  function automatic void door_to(logic [1:0] ph);
    m_door = ph;
    m_timer = 0;
  endfunction

  function automatic void car_halt(longint tgt);
    m_mode = ecmd_pkg::MODE_STOPPED;
    m_spd = 0;
    if (car_near(tgt)) door_to(ecmd_pkg::DOOR_OPENING);
  endfunction

  function automatic void car_tick(longint unsigned dus, longint tgt);
    longint unsigned dec, drop;
    longint gap;
    dec = (c_dec != 0) ? c_dec : 1;
    gap = tgt - m_hgt;
    if (gap < 0) gap = -gap;
    if (m_spd == 0 && m_door != ecmd_pkg::DOOR_CLOSED) begin
      m_timer += dus / 1000;
      if (m_timer > 131071) m_timer = 131071;
      if (m_door == ecmd_pkg::DOOR_OPEN) begin
        if (m_timer >= c_hold) door_to(ecmd_pkg::DOOR_CLOSING);
        return;
      end
      if (m_door == ecmd_pkg::DOOR_OPENING) begin
        if (m_timer >= c_move) door_to(ecmd_pkg::DOOR_OPEN);
        return;
      end
      if (m_timer < c_move) return;
      door_to(ecmd_pkg::DOOR_CLOSED);
    end
    if (m_spd == 0 && car_near(tgt)) return;
    if ((m_mode == ecmd_pkg::MODE_ACCEL || m_mode == ecmd_pkg::MODE_MAXV) &&
        longint'(gap) * 2 * dec <= m_spd * m_spd)
      m_mode = ecmd_pkg::MODE_DECEL;
    case (m_mode)
      ecmd_pkg::MODE_STOPPED: begin
        m_up = tgt > m_hgt;
        m_mode = ecmd_pkg::MODE_ACCEL;
      end
      ecmd_pkg::MODE_ACCEL: begin
        if (m_spd < c_vmax) begin
          m_spd += c_acc * dus / 1000000;
          if (m_spd > c_vmax) begin
            m_spd = c_vmax;
            m_mode = ecmd_pkg::MODE_MAXV;
          end
        end
      end
      ecmd_pkg::MODE_DECEL: begin
        if (m_spd > 0) begin
          drop = dec * dus / 1000000;
          if (drop >= m_spd) car_halt(tgt);
          else m_spd -= drop;
        end
      end
      default: ;
    endcase
    if (m_up) m_hgt += longint'(m_spd * dus / 1000000);
    else m_hgt -= longint'(m_spd * dus / 1000000);
    if (m_hgt > longint'(c_max)) begin
      m_hgt = c_max;
      car_halt(tgt);
    end
    if (m_hgt < longint'(c_min)) begin
      m_hgt = c_min;
      car_halt(tgt);
    end
  endfunction

  function automatic car_view_t car_apply(logic [1:0] f, logic [19:0] dus, logic [30:0] tgt,
                                          logic [18:0] wgt);
    car_view_t v;
    logic [1:0] e;
    e = ecmd_pkg::ERR_NONE;
    if (f == ecmd_pkg::FUNC_TICK) begin
      car_tick(dus, tgt);
    end else if (f == ecmd_pkg::FUNC_ENTER) begin
      if (m_riders >= c_plim || m_riders >= 63) e = ecmd_pkg::ERR_FULL;
      else begin
        m_load += wgt;
        if (m_load > 24'hFFFFFF) m_load = 24'hFFFFFF;
        m_riders++;
      end
    end else if (f == ecmd_pkg::FUNC_EXIT) begin
      if (m_riders == 0) e = ecmd_pkg::ERR_EMPTY;
      else begin
        m_load = (m_load > wgt) ? m_load - wgt : 0;
        m_riders--;
      end
    end
    v.mode = m_mode;
    v.door = m_door;
    v.up = m_up;
    v.alt = m_hgt[30:0];
    v.spd = m_spd[23:0];
    v.riders = m_riders[5:0];
    v.load = m_load[23:0];
    v.err = e;
    return v;
  endfunction

  function automatic void car_reset();
    c_vmax = 1000000; c_acc = 500000; c_dec = 500000; c_min = 0; c_max = 30000000;
    c_move = 2000; c_hold = 3000; c_plim = 8;
    m_mode = ecmd_pkg::MODE_STOPPED; m_door = ecmd_pkg::DOOR_CLOSED; m_up = 1'b0;
    m_hgt = 0; m_spd = 0; m_timer = 0; m_riders = 0; m_load = 0;
  endfunction

  // Write one register; the block must be idle
  task automatic reg_write(logic [2:0] idx, logic [30:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ecmd_pkg::REG_MAX_VEL:   c_vmax = val[23:0];
      ecmd_pkg::REG_ACCEL:     c_acc = val[23:0];
      ecmd_pkg::REG_DECEL:     c_dec = val[23:0];
      ecmd_pkg::REG_MIN_ALT:   c_min = val;
      ecmd_pkg::REG_MAX_ALT:   c_max = val;
      ecmd_pkg::REG_DOOR_MOVE: c_move = val[15:0];
      ecmd_pkg::REG_DOOR_HOLD: c_hold = val[15:0];
      default:                 c_plim = val[5:0];
    endcase
  endtask

  // Offer one item, hold it until transfer, queue its predicted view;
  // valid drops only while the sender idles or the bench drains
  task automatic send_item(logic [1:0] f, logic [19:0] dus, logic [30:0] tgt,
                           logic [18:0] wgt, bit has_exp, car_view_t exp_view);
    car_view_t v;
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    delta_us_i <= dus;
    target_altitude_i <= tgt;
    person_weight_i <= wgt;
    do @(posedge clk_i); while (!in_ready_o);
    v = car_apply(f, dus, tgt, wgt);
    if (has_exp && v != exp_view) begin
      $display("%0t: directed row disagrees with predictor: exp %h model %h",
               $time, exp_view, v);
      errors++;
    end
    pending_views.push_back(v);
    n_sent++;
    if (f == ecmd_pkg::FUNC_TICK) n_ticks++;
    if (v.mode != ecmd_pkg::MODE_STOPPED) n_moving++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= idle_out);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    car_view_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{motion_state_o, door_phase_o, moving_up_o, altitude_now_o, speed_now_o,
              passenger_count_o, load_grams_o, error_code_o};
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_views.pop_front();
        n_seen++;
        if (got.mode != want.mode)
          $display("%0t: motion_state exp %0d got %0d", $time, want.mode, got.mode);
        if (got.door != want.door)
          $display("%0t: door_phase exp %0d got %0d", $time, want.door, got.door);
        if (got.up != want.up)
          $display("%0t: moving_up exp %0d got %0d", $time, want.up, got.up);
        if (got.alt != want.alt)
          $display("%0t: altitude_now exp %0d got %0d", $time, want.alt, got.alt);
        if (got.spd != want.spd)
          $display("%0t: speed_now exp %0d got %0d", $time, want.spd, got.spd);
        if (got.riders != want.riders)
          $display("%0t: passenger_count exp %0d got %0d", $time, want.riders, got.riders);
        if (got.load != want.load)
          $display("%0t: load_grams exp %0d got %0d", $time, want.load, got.load);
        if (got.err != want.err)
          $display("%0t: error_code exp %0d got %0d", $time, want.err, got.err);
        if (got != want) errors++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_elevator_car_motion_and_door: FAIL");
      $finish;
    end
  end

  // Random item: mostly ticks toward a chosen floor, some riders, some noise
  task automatic random_item(logic [30:0] floor_tgt);
    int unsigned r;
    logic [1:0] f;
    logic [19:0] dus;
    logic [30:0] tgt;
    logic [18:0] wgt;
    r = $urandom_range(99);
    wgt = (r % 7 == 0) ? 19'($urandom()) : 19'($urandom_range(500000));
    tgt = floor_tgt;
    dus = '0;
    if (r < 70) begin
      f = ecmd_pkg::FUNC_TICK;
      case ($urandom_range(7))
        0: dus = 20'($urandom());
        1: dus = 20'($urandom_range(999));
        2: dus = 20'd1000000;
        default: dus = 20'($urandom_range(200000));
      endcase
      if ($urandom_range(19) == 0) tgt = 31'($urandom());
    end else if (r < 84) begin
      f = ecmd_pkg::FUNC_ENTER;
    end else if (r < 97) begin
      f = ecmd_pkg::FUNC_EXIT;
    end else begin
      f = ecmd_pkg::FUNC_SPARE;
      dus = 20'($urandom());
      tgt = 31'($urandom());
    end
    send_item(f, dus, tgt, wgt, 1'b0, '0);
  endtask

  stim_row_t rows[$];

  function automatic car_view_t view(logic [1:0] mo, logic [1:0] dr, logic [5:0] rd,
                                     logic [23:0] ld, logic [1:0] e);
    return '{mo, dr, 1'b0, 31'd0, 24'd0, rd, ld, e};
  endfunction

  initial begin
    logic [30:0] floor_tgt;
    car_reset();
    // Directed rows: known results after reset, extremes, error codes
    rows = '{
      '{ecmd_pkg::FUNC_EXIT, 20'd0, 31'd0, 19'd5, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 0, 0, ecmd_pkg::ERR_EMPTY)},
      '{ecmd_pkg::FUNC_TICK, 20'd0, 31'd0, 19'd0, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 0, 0, ecmd_pkg::ERR_NONE)},
      '{ecmd_pkg::FUNC_ENTER, 20'd0, 31'd0, 19'h7FFFF, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 1, 24'h7FFFF,
             ecmd_pkg::ERR_NONE)},
      '{ecmd_pkg::FUNC_EXIT, 20'd0, 31'd0, 19'h7FFFF, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 0, 0, ecmd_pkg::ERR_NONE)},
      '{ecmd_pkg::FUNC_SPARE, 20'hFFFFF, 31'h7FFFFFFF, 19'h7FFFF, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 0, 0, ecmd_pkg::ERR_NONE)},
      '{ecmd_pkg::FUNC_TICK, 20'd9999, 31'd10000, 19'd0, 1'b1,
        view(ecmd_pkg::MODE_STOPPED, ecmd_pkg::DOOR_CLOSED, 0, 0, ecmd_pkg::ERR_NONE)},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'hFFFFF, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_ENTER, 20'd0, 31'd0, 19'd400000, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd5000000, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'h7FFFFFFF, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'h7FFFFFFF, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_TICK, 20'd1000000, 31'd0, 19'd0, 1'b0, '0},
      '{ecmd_pkg::FUNC_EXIT, 20'd0, 31'd0, 19'd1, 1'b0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_in = 9;
    idle_out = 52;
    foreach (rows[i])
      send_item(rows[i].func, rows[i].dus, rows[i].tgt, rows[i].wgt,
                rows[i].has_exp, rows[i].exp_view);
    drain();

    // Full car with a small limit, and load saturation at the largest limit
    reg_write(ecmd_pkg::REG_PASS_LIM, 31'd2);
    repeat (4) send_item(ecmd_pkg::FUNC_ENTER, 0, 0, 19'd300000, 1'b0, '0);
    drain();
    reg_write(ecmd_pkg::REG_PASS_LIM, 31'd63);
    repeat (66) send_item(ecmd_pkg::FUNC_ENTER, 0, 0, 19'd500000, 1'b0, '0);
    repeat (66) send_item(ecmd_pkg::FUNC_EXIT, 0, 0, 19'd300000, 1'b0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        idle_in = 52;
        idle_out = 9;
      end
      if (ph == 4) begin
        idle_in = 0;
        idle_out = 0;
      end
      // Each phase takes its own setting; the first and last use the extremes
      case (ph)
        0: begin
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd10000000);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd10000000);
          reg_write(ecmd_pkg::REG_DECEL, 31'd1);
          reg_write(ecmd_pkg::REG_MIN_ALT, 31'd0);
          reg_write(ecmd_pkg::REG_MAX_ALT, 31'h7FFFFFFF);
          reg_write(ecmd_pkg::REG_DOOR_MOVE, 31'd0);
          reg_write(ecmd_pkg::REG_DOOR_HOLD, 31'd0);
          reg_write(ecmd_pkg::REG_PASS_LIM, 31'd0);
        end
        1: begin
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd2000000);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd800000);
          reg_write(ecmd_pkg::REG_DECEL, 31'd0);
          reg_write(ecmd_pkg::REG_MIN_ALT, 31'd1000000);
          reg_write(ecmd_pkg::REG_MAX_ALT, 31'd40000000);
          reg_write(ecmd_pkg::REG_DOOR_MOVE, 31'd1500);
          reg_write(ecmd_pkg::REG_DOOR_HOLD, 31'd65535);
          reg_write(ecmd_pkg::REG_PASS_LIM, 31'd5);
        end
        2: begin
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd0);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd1);
          reg_write(ecmd_pkg::REG_DECEL, 31'd10000000);
          reg_write(ecmd_pkg::REG_DOOR_MOVE, 31'd65535);
          reg_write(ecmd_pkg::REG_PASS_LIM, 31'd63);
        end
        3: begin
          // min above max: the lower limit wins
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd1500000);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd600000);
          reg_write(ecmd_pkg::REG_DECEL, 31'd700000);
          reg_write(ecmd_pkg::REG_MIN_ALT, 31'd20000000);
          reg_write(ecmd_pkg::REG_MAX_ALT, 31'd10000000);
          reg_write(ecmd_pkg::REG_DOOR_MOVE, 31'd300);
          reg_write(ecmd_pkg::REG_DOOR_HOLD, 31'd500);
        end
        4: begin
          reg_write(ecmd_pkg::REG_MIN_ALT, 31'd0);
          reg_write(ecmd_pkg::REG_MAX_ALT, 31'd30000000);
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd3000000);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd2000000);
          reg_write(ecmd_pkg::REG_DECEL, 31'd1500000);
          reg_write(ecmd_pkg::REG_PASS_LIM, 31'd8);
        end
        default: begin
          reg_write(ecmd_pkg::REG_MAX_VEL, 31'd1000000);
          reg_write(ecmd_pkg::REG_ACCEL, 31'd500000);
          reg_write(ecmd_pkg::REG_DECEL, 31'd500000);
          reg_write(ecmd_pkg::REG_MIN_ALT, 31'h7FFFFFFF);
          reg_write(ecmd_pkg::REG_MAX_ALT, 31'h7FFFFFFF);
          reg_write(ecmd_pkg::REG_DOOR_MOVE, 31'd2000);
          reg_write(ecmd_pkg::REG_DOOR_HOLD, 31'd3000);
          reg_write(ecmd_pkg::REG_PASS_LIM, 31'd63);
        end
      endcase
      floor_tgt = 31'($urandom_range(32000000));
      for (int k = 0; k < 240; k++) begin
        if ($urandom_range(29) == 0) floor_tgt = 31'($urandom_range(32000000));
        // Hold off the receiver once while items keep coming
        if (ph == 4 && k == 20) fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
        random_item(floor_tgt);
      end
      drain();
    end

    $display("Covered %0d items (%0d ticks, %0d seen with the car moving), %0d results.",
             n_sent, n_ticks, n_moving, n_seen);
    $display("Door, motion profile, shaft clamps and load limits run under six settings.");
    if (errors == 0 && pending_views.size() == 0) begin
      $display("tb_elevator_car_motion_and_door: PASS");
    end else begin
      $display("tb_elevator_car_motion_and_door: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/ecmd_pkg.sv
src/ecmd_mul.sv
src/ecmd_div.sv
src/elevator_car_motion_and_door.sv
src/ecmd_chk.sv
tb/sv/tb_elevator_car_motion_and_door.sv
